// ===== hdl/lfu_pkg.sv =====
// shared constants and types for the lfu page replacement unit
package lfu_pkg;

	// fixed port widths
	localparam int PAGE_IN_W   = 16;
	localparam int INDEX_OUT_W = 4;
	localparam int EVICT_OUT_W = 16;
	localparam int FAULT_W     = 16;
	localparam int CFG_W       = 5;

	// apb port
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// register map
	localparam logic [APB_AW-1:0] ADDR_FRAME_COUNT = 3'd0;

	// saturation limit of the fault total
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	// strobes from the sequencer to the scan unit
	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

endpackage

// ===== hdl/lfu_cfg_regs.sv =====
// apb register for the frame count and its clamped effective value
module lfu_cfg_regs
	import lfu_pkg::*;
#(
	parameter int FRAMES = 16,
	localparam int FILL_W = $clog2(FRAMES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic [FILL_W-1:0] eff_frames
);

	logic [CFG_W-1:0] frame_count_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= CFG_W'(16);
		end else if (psel && penable && pwrite && paddr == ADDR_FRAME_COUNT) begin
			frame_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_FRAME_COUNT) begin
			prdata = APB_DW'(frame_count_q);
		end
	end

	// zero acts as one, oversize acts as the built frame count
	always_comb begin
		if (frame_count_q == '0) begin
			eff_frames = FILL_W'(1);
		end else if (int'(frame_count_q) > FRAMES) begin
			eff_frames = FILL_W'(FRAMES);
		end else begin
			eff_frames = FILL_W'(frame_count_q);
		end
	end

endmodule

// ===== hdl/lfu_scan.sv =====
// tracks the matching frame and the least used frame while the table streams by
module lfu_scan
	import lfu_pkg::*;
#(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16,
	parameter int USE_WIDTH  = 16,
	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scan_ctl_t             ctl,
	input  logic [IDX_W-1:0]      idx,
	input  logic [PAGE_WIDTH-1:0] rd_page,
	input  logic [USE_WIDTH-1:0]  rd_uses,
	input  logic [PAGE_WIDTH-1:0] key,
	output logic                  found_q,
	output logic [IDX_W-1:0]      match_idx_q,
	output logic [USE_WIDTH-1:0]  match_uses_q,
	output logic [IDX_W-1:0]      min_idx_q,
	output logic [PAGE_WIDTH-1:0] min_page_q
);

	logic                 first_q;
	logic [USE_WIDTH-1:0] min_uses_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.valid) begin
			first_q <= 1'b0;
			if (rd_page == key) begin
				found_q <= 1'b1;
			end
		end
	end

	// match capture
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.clear && rd_page == key) begin
			match_idx_q  <= idx;
			match_uses_q <= rd_uses;
		end
	end

	// least used frame, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.clear && (first_q || rd_uses < min_uses_q)) begin
			min_idx_q  <= idx;
			min_uses_q <= rd_uses;
			min_page_q <= rd_page;
		end
	end

endmodule

// ===== hdl/lfu_page_replacement_unit.sv =====
// lfu page replacement unit: frame table memory, scan sequencer and result register
// a page is accepted only in idle, scanned over the filled frames (none while empty),
// then the update writes the table and result, waiting while an unread result is held
// the frame table is a single memory with a registered read, scanned once per item
// reset clears the fill count, fault total, control and frame count (16); table contents
// are left as they are and only filled entries are ever read
module lfu_page_replacement_unit
	import lfu_pkg::*;
#(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16,
	parameter int USE_WIDTH  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	input  logic                   page_valid,
	output logic                   page_ready,
	input  logic [PAGE_IN_W-1:0]   page,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   hit,
	output logic [INDEX_OUT_W-1:0] frame_index,
	output logic                   evicted_valid,
	output logic [EVICT_OUT_W-1:0] evicted_page,
	output logic [FAULT_W-1:0]     fault_total
);

	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W  = $clog2(FRAMES + 1);
	localparam int ENTRY_W = PAGE_WIDTH + USE_WIDTH;
	localparam logic [USE_WIDTH-1:0] USE_MAX = '1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]            state_q;
	logic [FILL_W-1:0]     eff_frames;
	logic [FILL_W-1:0]     filled_q;
	logic [FAULT_W-1:0]    faults_q;
	logic [PAGE_WIDTH-1:0] key_q;
	logic                  issue_q;
	logic [FILL_W-1:0]     rd_addr_q;
	logic                  rv_s1;
	logic [FILL_W-1:0]     ridx_s1;
	logic [ENTRY_W-1:0]    rd_data_s1;
	scan_ctl_t             scan_ctl;
	logic                  found;
	logic [IDX_W-1:0]      match_idx;
	logic [USE_WIDTH-1:0]  match_uses;
	logic [IDX_W-1:0]      min_idx;
	logic [PAGE_WIDTH-1:0] min_page;
	logic                  upd_go;
	logic                  do_fill;
	logic [IDX_W-1:0]      slot;
	logic [USE_WIDTH-1:0]  new_uses;
	logic [ENTRY_W-1:0]    mem_q [FRAMES];

	logic                   hit_q;
	logic [INDEX_OUT_W-1:0] frame_index_q;
	logic                   evicted_valid_q;
	logic [EVICT_OUT_W-1:0] evicted_page_q;
	logic                   out_valid_q;

	// configuration register
	lfu_cfg_regs #(
		.FRAMES(FRAMES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.eff_frames(eff_frames)
	);

	assign pready = 1'b1;

	// scan strobes
	assign scan_ctl.clear = page_valid && page_ready;
	assign scan_ctl.valid = rv_s1;

	lfu_scan #(
		.FRAMES    (FRAMES),
		.PAGE_WIDTH(PAGE_WIDTH),
		.USE_WIDTH (USE_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.idx         (ridx_s1[IDX_W-1:0]),
		.rd_page     (rd_data_s1[ENTRY_W-1:USE_WIDTH]),
		.rd_uses     (rd_data_s1[USE_WIDTH-1:0]),
		.key         (key_q),
		.found_q     (found),
		.match_idx_q (match_idx),
		.match_uses_q(match_uses),
		.min_idx_q   (min_idx),
		.min_page_q  (min_page)
	);

	assign page_ready = (state_q == ST_IDLE);

	// update decision: hit, fill a free frame or replace the least used one
	assign upd_go  = (state_q == ST_UPD) && (!out_valid_q || result_ready);
	assign do_fill = !found && (filled_q < eff_frames);

	always_comb begin
		if (found) begin
			slot = match_idx;
		end else if (do_fill) begin
			slot = filled_q[IDX_W-1:0];
		end else begin
			slot = min_idx;
		end
	end

	assign new_uses = !found ? USE_WIDTH'(1) :
	                  (match_uses == USE_MAX) ? match_uses : match_uses + USE_WIDTH'(1);

	// frame table memory
	always_ff @(posedge clk) begin
		if (upd_go) begin
			mem_q[slot] <= {key_q, new_uses};
		end
		if (state_q == ST_SCAN && issue_q) begin
			rd_data_s1 <= mem_q[rd_addr_q[IDX_W-1:0]];
		end
	end

	// read index pipeline
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && issue_q) begin
			ridx_s1 <= rd_addr_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issue_q   <= 1'b0;
			rd_addr_q <= '0;
			rv_s1     <= 1'b0;
			filled_q  <= '0;
			faults_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rv_s1 <= 1'b0;
					if (page_valid) begin
						rd_addr_q <= '0;
						issue_q   <= (filled_q != '0);
						state_q   <= (filled_q != '0) ? ST_SCAN : ST_UPD;
					end
				end
				ST_SCAN: begin
					rv_s1 <= issue_q;
					if (issue_q) begin
						rd_addr_q <= rd_addr_q + FILL_W'(1);
						if (rd_addr_q == filled_q - FILL_W'(1)) begin
							issue_q <= 1'b0;
						end
					end
					if (rv_s1 && ridx_s1 == filled_q - FILL_W'(1)) begin
						state_q <= ST_UPD;
						rv_s1   <= 1'b0;
					end
				end
				ST_UPD: begin
					rv_s1 <= 1'b0;
					if (upd_go) begin
						state_q <= ST_IDLE;
						if (do_fill) begin
							filled_q <= filled_q + FILL_W'(1);
						end
						if (!found && faults_q != FAULT_MAX) begin
							faults_q <= faults_q + FAULT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
					rv_s1   <= 1'b0;
				end
			endcase
		end
	end

	// key capture
	always_ff @(posedge clk) begin
		if (page_valid && page_ready) begin
			key_q <= PAGE_WIDTH'(page);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (upd_go) begin
			hit_q           <= found;
			frame_index_q   <= INDEX_OUT_W'(slot);
			evicted_valid_q <= !found && !do_fill;
			evicted_page_q  <= (!found && !do_fill) ? EVICT_OUT_W'(min_page) : '0;
		end
	end

	assign result_valid  = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = faults_q;

endmodule
